### design/rsh_pkg.sv
package rsh_pkg;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int COLOR_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int LIMB_W    = 22;
    localparam int WIDE_W    = 3 * LIMB_W;
    localparam int ROW_W     = 4 * LIMB_W;
    localparam int PROD_W    = 6 * LIMB_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS
    } t_cfg_idx;

    localparam logic [COORD_W-1:0] CENTER_Z_RST = 32'hFFFF_0000;
    localparam logic [RAD_W-1:0]   RADIUS_RST   = 31'd32768;
    localparam logic [COLOR_W-1:0] COLOR_ONE    = 16'd32768;
    localparam logic [31:0]        ONE_Q30      = 32'h4000_0000;
    localparam logic [30:0]        T_HALF       = 31'h2000_0000;
    localparam logic [33:0]        GREEN_NUM    = 34'd10737418240;
    localparam logic [19:0]        GREEN_RECIP  = 20'd838861;

    typedef struct packed {
        logic        hit;
        logic [63:0] a;
        logic        yneg;
        logic [31:0] ymag;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_push;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_pop;

    typedef struct packed {
        logic        hit;
        logic        yneg;
        logic [31:0] ymag;
    } t_bk_side;

    typedef struct packed {
        logic az;
        logic cl;
        logic hn;
    } t_fe_flags;

endpackage

### design/rsh_if.sv
interface rsh_dir_if import rsh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface rsh_pix_if import rsh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    modport source (output valid, output hit, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input hit, input red, input green, input blue,
                  output ready);
endinterface

interface rsh_cfg_if import rsh_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/rsh_front.sv
module rsh_front import rsh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rsh_cfg_if.sink i_cfg,
    rsh_dir_if.sink i_dir,
    input  logic    i_full,
    output t_q_push o_push
);

    logic signed [COORD_W-1:0] r_org [3];
    logic signed [COORD_W-1:0] r_ctr [3];
    logic [RAD_W-1:0]          r_rad;
    logic signed [COORD_W:0]   r_oc [3];
    logic [2*RAD_W-1:0]        r_r2;

    logic [6:0]                r_v;
    logic                      fe_adv;

    logic signed [COORD_W-1:0] r_d [3];
    logic [31:0]               w_md [3];
    logic [32:0]               w_mo [3];
    logic [63:0]               r_aa [3];
    logic [64:0]               r_od [3];
    logic [65:0]               r_oo [3];
    logic                      r_ng [3];
    logic                      r_yn [1:6];
    logic [31:0]               r_ym [1:6];

    logic [63:0]               r_a [2:6];
    logic [WIDE_W-1:0]         r_pos;
    logic [WIDE_W-1:0]         r_neg;
    logic [WIDE_W-1:0]         r_cs;
    logic [63:0]               w_a;
    logic [WIDE_W-1:0]         w_pos;
    logic [WIDE_W-1:0]         w_neg;
    logic [WIDE_W-1:0]         w_cs;

    t_fe_flags                 r_fl [3:6];
    logic [WIDE_W-1:0]         r_hw;
    logic [WIDE_W-1:0]         r_cw;
    logic [WIDE_W-1:0]         w_a66;

    logic [2*LIMB_W-1:0]       r_phh [9];
    logic [2*LIMB_W-1:0]       r_pac [9];
    logic [2*LIMB_W-1:0]       w_phh [9];
    logic [2*LIMB_W-1:0]       w_pac [9];
    logic [ROW_W-1:0]          r_rhh [3];
    logic [ROW_W-1:0]          r_rac [3];
    logic [ROW_W-1:0]          w_rhh [3];
    logic [ROW_W-1:0]          w_rac [3];
    logic [PROD_W-1:0]         r_thh;
    logic [PROD_W-1:0]         r_tac;
    logic [PROD_W-1:0]         w_thh;
    logic [PROD_W-1:0]         w_tac;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_ctr[0] <= '0;
            r_ctr[1] <= '0;
            r_ctr[2] <= CENTER_Z_RST;
            r_rad    <= RADIUS_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ORIGIN_X: r_org[0] <= i_cfg.data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg.data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg.data;
                CFG_CENTER_X: r_ctr[0] <= i_cfg.data;
                CFG_CENTER_Y: r_ctr[1] <= i_cfg.data;
                CFG_CENTER_Z: r_ctr[2] <= i_cfg.data;
                CFG_RADIUS:   r_rad    <= i_cfg.data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_oc[i] <= {r_org[i][COORD_W-1], r_org[i]} - {r_ctr[i][COORD_W-1], r_ctr[i]};
        end
        r_r2 <= r_rad * r_rad;
    end

    // pipeline control
    assign fe_adv      = !(r_v[6] && i_full);
    assign i_dir.ready = fe_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (fe_adv) begin
            r_v <= {r_v[5:0], i_dir.valid};
        end
    end

    // magnitudes of direction and origin-to-center
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_md[i] = r_d[i][COORD_W-1] ? (~r_d[i] + 32'd1) : r_d[i];
            w_mo[i] = r_oc[i][COORD_W] ? (~r_oc[i] + 33'd1) : r_oc[i];
        end
    end

    // dot products
    always_comb begin
        w_a   = r_aa[0] + r_aa[1] + r_aa[2];
        w_pos = '0;
        w_neg = '0;
        w_cs  = WIDE_W'(r_oo[0]) + WIDE_W'(r_oo[1]) + WIDE_W'(r_oo[2]);
        for (int i = 0; i < 3; i++) begin
            if (r_ng[i]) begin
                w_neg = w_neg + WIDE_W'(r_od[i]);
            end else begin
                w_pos = w_pos + WIDE_W'(r_od[i]);
            end
        end
    end

    // limb products for h*h and a*c
    assign w_a66 = WIDE_W'(r_a[3]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_phh[3*i+j] = r_hw[LIMB_W*i +: LIMB_W] * r_hw[LIMB_W*j +: LIMB_W];
                w_pac[3*i+j] = w_a66[LIMB_W*i +: LIMB_W] * r_cw[LIMB_W*j +: LIMB_W];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rhh[i] = ROW_W'(r_phh[3*i]) + (ROW_W'(r_phh[3*i+1]) << LIMB_W)
                     + (ROW_W'(r_phh[3*i+2]) << 2*LIMB_W);
            w_rac[i] = ROW_W'(r_pac[3*i]) + (ROW_W'(r_pac[3*i+1]) << LIMB_W)
                     + (ROW_W'(r_pac[3*i+2]) << 2*LIMB_W);
        end
        w_thh = PROD_W'(r_rhh[0]) + (PROD_W'(r_rhh[1]) << LIMB_W)
              + (PROD_W'(r_rhh[2]) << 2*LIMB_W);
        w_tac = PROD_W'(r_rac[0]) + (PROD_W'(r_rac[1]) << LIMB_W)
              + (PROD_W'(r_rac[2]) << 2*LIMB_W);
    end

    always_ff @(posedge i_clk) begin
        if (fe_adv) begin
            r_d[0] <= i_dir.dir_x;
            r_d[1] <= i_dir.dir_y;
            r_d[2] <= i_dir.dir_z;

            for (int i = 0; i < 3; i++) begin
                r_aa[i] <= w_md[i] * w_md[i];
                r_od[i] <= w_mo[i] * w_md[i];
                r_oo[i] <= w_mo[i] * w_mo[i];
                r_ng[i] <= r_oc[i][COORD_W] ^ r_d[i][COORD_W-1];
            end
            r_yn[1] <= r_d[1][COORD_W-1];
            r_ym[1] <= w_md[1];
            for (int s = 2; s <= 6; s++) begin
                r_yn[s] <= r_yn[s-1];
                r_ym[s] <= r_ym[s-1];
            end

            r_a[2] <= w_a;
            r_pos  <= w_pos;
            r_neg  <= w_neg;
            r_cs   <= w_cs;

            r_a[3]    <= r_a[2];
            r_fl[3].az <= (r_a[2] == '0);
            r_fl[3].cl <= (r_cs < WIDE_W'(r_r2));
            r_fl[3].hn <= (r_neg > r_pos);
            r_hw      <= r_neg - r_pos;
            r_cw      <= r_cs - WIDE_W'(r_r2);

            r_a[4]  <= r_a[3];
            r_fl[4] <= r_fl[3];
            r_phh   <= w_phh;
            r_pac   <= w_pac;

            r_a[5]  <= r_a[4];
            r_fl[5] <= r_fl[4];
            r_rhh   <= w_rhh;
            r_rac   <= w_rac;

            r_a[6]  <= r_a[5];
            r_fl[6] <= r_fl[5];
            r_thh   <= w_thh;
            r_tac   <= w_tac;
        end
    end

    // classify and hand over
    always_comb begin
        o_push.valid     = r_v[6] && !i_full;
        o_push.item.hit  = !r_fl[6].az && (r_fl[6].cl || (r_fl[6].hn && (r_thh >= r_tac)));
        o_push.item.a    = r_a[6];
        o_push.item.yneg = r_yn[6];
        o_push.item.ymag = r_ym[6];
    end

endmodule

### design/rsh_queue.sv
module rsh_queue import rsh_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_pop  o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item       r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rp];
    assign w_wr         = i_push.valid && !o_full;
    assign w_rd         = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/rsh_back.sv
module rsh_back import rsh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_pop    i_head,
    output logic      o_pop,
    rsh_pix_if.source o_pix
);

    logic          be_adv;

    // square root stages
    logic          r_sv [0:32];
    logic [63:0]   r_sa [0:32];
    logic [32:0]   r_sr [0:32];
    logic [31:0]   r_sq [0:32];
    t_bk_side      r_ss [0:32];

    // divide stages
    logic          r_dv [0:31];
    logic [31:0]   r_dr [0:31];
    logic [30:0]   r_dq [0:31];
    logic [31:0]   r_dl [0:31];
    t_bk_side      r_ds [0:31];

    // color stages
    logic          r_c1v;
    logic          r_c1hit;
    logic [15:0]   r_c1red;
    logic [18:0]   r_c1num;
    logic          r_c2v;
    logic          r_c2hit;
    logic [15:0]   r_c2red;
    logic [38:0]   r_c2prod;

    logic          r_ov;
    logic          r_ohit;
    logic [15:0]   r_ored;
    logic [15:0]   r_ogrn;
    logic [15:0]   r_oblu;

    logic [30:0]   w_t;
    logic [31:0]   w_tsum;
    logic [45:0]   w_red46;
    logic [15:0]   w_red;
    logic [32:0]   w_t3;
    logic [33:0]   w_gnum;
    logic [15:0]   w_grn;

    assign be_adv = !r_ov || o_pix.ready;
    assign o_pop  = be_adv && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (be_adv) begin
            r_sa[0]      <= i_head.item.a;
            r_sr[0]      <= '0;
            r_sq[0]      <= '0;
            r_ss[0].hit  <= i_head.item.hit;
            r_ss[0].yneg <= i_head.item.yneg;
            r_ss[0].ymag <= i_head.item.ymag;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        logic [34:0] w_sh;
        logic [34:0] w_tr;
        logic        w_ge;

        assign w_sh = {r_sr[k], r_sa[k][63-2*k -: 2]};
        assign w_tr = {1'b0, r_sq[k], 2'b01};
        assign w_ge = (w_sh >= w_tr);

        always_ff @(posedge i_clk) begin
            if (be_adv) begin
                r_sa[k+1] <= r_sa[k];
                r_sr[k+1] <= w_ge ? 33'(w_sh - w_tr) : 33'(w_sh);
                r_sq[k+1] <= {r_sq[k][30:0], w_ge};
                r_ss[k+1] <= r_ss[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (be_adv) begin
            r_dr[0] <= {1'b0, r_ss[32].ymag[31:1]};
            r_dq[0] <= '0;
            r_dl[0] <= r_sq[32];
            r_ds[0] <= r_ss[32];
        end
    end

    for (genvar j = 0; j < 31; j++) begin : g_div
        logic        w_bit;
        logic [32:0] w_sh;
        logic        w_ge;

        if (j == 0) begin : g_first
            assign w_bit = r_ds[j].ymag[0];
        end else begin : g_rest
            assign w_bit = 1'b0;
        end
        assign w_sh = {r_dr[j], w_bit};
        assign w_ge = (w_sh >= {1'b0, r_dl[j]});

        always_ff @(posedge i_clk) begin
            if (be_adv) begin
                r_dr[j+1] <= w_ge ? 32'(w_sh - {1'b0, r_dl[j]}) : w_sh[31:0];
                r_dq[j+1] <= {r_dq[j][29:0], w_ge};
                r_dl[j+1] <= r_dl[j];
                r_ds[j+1] <= r_ds[j];
            end
        end
    end

    // blend factor and channels
    always_comb begin
        w_tsum = r_ds[31].yneg ? (ONE_Q30 - {1'b0, r_dq[31]}) : (ONE_Q30 + {1'b0, r_dq[31]});
        w_t    = (r_dl[31] == '0) ? T_HALF : w_tsum[31:1];
        w_red46 = {1'b1, 45'b0} - {1'b0, w_t, 14'b0};
        w_red   = (w_red46[45:30] > COLOR_ONE) ? COLOR_ONE : w_red46[45:30];
        w_t3    = {2'b0, w_t} + {1'b0, w_t, 1'b0};
        w_gnum  = GREEN_NUM - {1'b0, w_t3};
        w_grn   = (r_c2prod[38:23] > COLOR_ONE) ? COLOR_ONE : r_c2prod[38:23];
    end

    always_ff @(posedge i_clk) begin
        if (be_adv) begin
            r_c1hit  <= r_ds[31].hit;
            r_c1red  <= w_red;
            r_c1num  <= w_gnum[33:15];
            r_c2hit  <= r_c1hit;
            r_c2red  <= r_c1red;
            r_c2prod <= r_c1num * GREEN_RECIP;
            r_ohit   <= r_c2hit;
            r_ored   <= r_c2hit ? COLOR_ONE : r_c2red;
            r_ogrn   <= r_c2hit ? '0 : w_grn;
            r_oblu   <= r_c2hit ? '0 : COLOR_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= 32; s++) begin
                r_sv[s] <= 1'b0;
            end
            for (int s = 0; s <= 31; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_c1v <= 1'b0;
            r_c2v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (be_adv) begin
            r_sv[0] <= i_head.valid;
            for (int s = 1; s <= 32; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
            r_dv[0] <= r_sv[32];
            for (int s = 1; s <= 31; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_c1v <= r_dv[31];
            r_c2v <= r_c1v;
            r_ov  <= r_c2v;
        end
    end

    assign o_pix.valid = r_ov;
    assign o_pix.hit   = r_ohit;
    assign o_pix.red   = r_ored;
    assign o_pix.green = r_ogrn;
    assign o_pix.blue  = r_oblu;

endmodule

### design/ray_sphere_hit_shader.sv
// ray / sphere hit shader
// i_cfg: register writes (index, data), always ready; write origin, center
//   and radius only while no item is in flight
// i_dir: one ray direction item per handshake (dir_x, dir_y, dir_z, Q16.16)
// o_pix: one result item per ray: hit flag and red, green, blue in Q1.15
// throughput: one item per cycle; the front, the queue and the back each
//   advance every cycle when nothing downstream stalls
// pipeline: 7 front stages for the quadratic and the discriminant test,
//   one queue slot, 32 square root stages, the divide stages and 3 color
//   stages including the output register
// o_pix stall: the back holds, the front keeps taking items until the
//   Q_DEPTH entry queue fills and the last front stage holds an item, then i_dir.ready drops
// reset: synchronous, active low; clears all valid flags and the queue and
//   loads origin 0, center (0, 0, -1.0) and radius 0.5
module ray_sphere_hit_shader import rsh_pkg::*; #(
    parameter int Q_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsh_cfg_if.sink   i_cfg,
    rsh_dir_if.sink   i_dir,
    rsh_pix_if.source o_pix
);

    t_q_push w_push;
    t_q_pop  w_head;
    logic    w_full;
    logic    w_pop;

    rsh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_dir   (i_dir),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    rsh_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    rsh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_pix   (o_pix)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_full)
        else $error("push into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from an empty queue");

    a_hit_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.hit) |->
        (o_pix.red == COLOR_ONE && o_pix.green == '0 && o_pix.blue == '0))
        else $error("hit item not red");

    a_sky_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.hit) |->
        (o_pix.blue == COLOR_ONE && o_pix.red <= COLOR_ONE && o_pix.green <= COLOR_ONE))
        else $error("sky color out of range");

endmodule
